// ----- rtl/mpc_pkg.sv -----
// Package for the masked Pearson correlation block.
// Widths, controller/datapath command and status types. No dependencies.
package mpc_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned MaxPairs   = 32768;
  localparam int unsigned CntBits    = 17;
  localparam int unsigned SumBits    = 32;
  localparam int unsigned SqBits     = 47;
  localparam int unsigned WideBits   = 160;
  localparam int unsigned MagBits    = 15;
  localparam int unsigned MulBits    = 32;

  // Datapath operations, one per sequencer step
  typedef enum logic [3:0] {
    OpNone,
    OpLoadA,
    OpLoadB,
    OpMulStep,
    OpSubX,
    OpSubY,
    OpSubN,
    OpDenom,
    OpNumSq,
    OpTrial,
    OpCompare,
    OpFinish,
    OpClear
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [2:0]       sel;
    logic             accum;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic degen;
  } dp_status_t;

endpackage

// ----- rtl/mpc_datapath.sv -----
// Datapath: accumulators, a shared 32x32 multiply-accumulate unit and the
// square-root search registers. Depends on mpc_pkg.
module mpc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_en_i,
  input  logic signed [15:0]            x_sample_i,
  input  logic signed [15:0]            y_sample_i,
  input  logic signed [15:0]            missing_code_i,
  input  mpc_pkg::dp_cmd_t              cmd_i,
  output mpc_pkg::dp_status_t           status_o,
  output logic signed [15:0]            r_value_o,
  output logic [15:0]                   pair_count_o,
  output logic                          degenerate_o
);
  import mpc_pkg::*;

  // Running sums
  logic [CntBits-1:0]         cnt_q;
  logic signed [SumBits-1:0]  sx_q, sy_q;
  logic signed [SqBits-1:0]   sxx_q, syy_q, sxy_q;

  // Multiply-accumulate: a_q * b_q over 32-bit limbs, unsigned magnitudes
  logic [WideBits-1:0] a_q, b_q, p_q;
  logic [2:0]          ai_q, bi_q;
  logic                mdone_q;
  logic [WideBits-1:0] dx_q, dy_q, den_q, num_q, nsq_q, t1_q;
  logic                nneg_q, t1neg_q, degen_q;
  logic [MagBits-1:0]  mag_q;
  logic [3:0]          bit_q;
  logic [MagBits-1:0]  trial;
  logic [2*MagBits-1:0] tsq;
  logic [MulBits-1:0]  la, lb;
  logic [63:0]         pp;
  logic                valid_pair;
  logic [WideBits-1:0] num_raw;
  logic                degen_now;

  assign valid_pair = (x_sample_i != missing_code_i) && (y_sample_i != missing_code_i) &&
                      (cnt_q < CntBits'(MaxPairs));
  assign la    = a_q[ai_q*MulBits +: MulBits];
  assign lb    = b_q[bi_q*MulBits +: MulBits];
  assign pp    = la * lb;
  assign trial = mag_q | (MagBits'(1) << bit_q);
  assign tsq   = (2*MagBits)'(trial) * (2*MagBits)'(trial);
  assign num_raw = t1_q - (t1neg_q ? WideBits'(-p_q) : p_q);
  assign degen_now = (dx_q == '0) || (dy_q == '0) || dx_q[WideBits-1] || dy_q[WideBits-1];

  function automatic logic [WideBits-1:0] sabs(input logic signed [WideBits-1:0] v);
    return v[WideBits-1] ? WideBits'(-v) : v;
  endfunction

  // Accumulate pairs and run the result sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sx_q <= '0; sy_q <= '0; sxx_q <= '0; syy_q <= '0; sxy_q <= '0;
      mdone_q <= 1'b0;
      a_q <= '0; b_q <= '0; p_q <= '0; ai_q <= '0; bi_q <= '0;
      dx_q <= '0; dy_q <= '0; den_q <= '0; num_q <= '0; nsq_q <= '0; t1_q <= '0;
      nneg_q <= 1'b0; t1neg_q <= 1'b0; degen_q <= 1'b0;
      mag_q <= '0; bit_q <= '0;
      r_value_o <= '0; pair_count_o <= '0; degenerate_o <= 1'b0;
    end else begin
      mdone_q <= 1'b0;
      if (acc_en_i && valid_pair) begin
        cnt_q <= cnt_q + 1'b1;
        sx_q  <= sx_q + SumBits'(x_sample_i);
        sy_q  <= sy_q + SumBits'(y_sample_i);
        sxx_q <= sxx_q + SqBits'(x_sample_i * x_sample_i);
        syy_q <= syy_q + SqBits'(y_sample_i * y_sample_i);
        sxy_q <= sxy_q + SqBits'(x_sample_i * y_sample_i);
      end
      case (cmd_i.op)
        OpLoadA: begin
          case (cmd_i.sel)
            3'd0: begin a_q <= WideBits'(cnt_q); b_q <= sabs(WideBits'(sxx_q)); end
            3'd1: begin a_q <= sabs(WideBits'(sx_q)); b_q <= sabs(WideBits'(sx_q)); end
            3'd2: begin a_q <= WideBits'(cnt_q); b_q <= sabs(WideBits'(syy_q)); end
            3'd3: begin a_q <= sabs(WideBits'(sy_q)); b_q <= sabs(WideBits'(sy_q)); end
            3'd4: begin a_q <= WideBits'(cnt_q); b_q <= sabs(WideBits'(sxy_q)); end
            3'd5: begin a_q <= sabs(WideBits'(sx_q)); b_q <= sabs(WideBits'(sy_q)); end
            3'd6: begin a_q <= dx_q; b_q <= dy_q; end
            default: begin a_q <= num_q; b_q <= num_q; end
          endcase
          ai_q <= '0; bi_q <= '0; p_q <= '0;
          // sign of the pending product
          case (cmd_i.sel)
            3'd4: t1neg_q <= sxy_q[SqBits-1];
            3'd5: t1neg_q <= sx_q[SumBits-1] ^ sy_q[SumBits-1];
            default: t1neg_q <= 1'b0;
          endcase
        end
        OpLoadB: begin
          a_q <= WideBits'(tsq);
          b_q <= den_q; ai_q <= '0; bi_q <= '0; p_q <= '0; t1neg_q <= 1'b0;
        end
        OpMulStep: begin
          p_q <= p_q + (WideBits'(pp) << ((ai_q + bi_q) * MulBits));
          if (bi_q == 3'd4) begin
            bi_q <= '0;
            if (ai_q == 3'd4) mdone_q <= 1'b1;
            else ai_q <= ai_q + 1'b1;
          end else begin
            bi_q <= bi_q + 1'b1;
          end
        end
        OpSubX: begin
          if (cmd_i.accum) t1_q <= p_q;
          else dx_q <= t1_q - p_q;
        end
        OpSubY: begin
          if (cmd_i.accum) t1_q <= p_q;
          else dy_q <= t1_q - p_q;
        end
        OpSubN: begin
          if (cmd_i.accum) begin
            t1_q <= t1neg_q ? WideBits'(-p_q) : p_q;
          end else begin
            num_q  <= sabs(num_raw);
            nneg_q <= num_raw[WideBits-1];
          end
        end
        OpDenom: begin
          degen_q <= degen_now;
          mag_q <= '0; bit_q <= 4'd14;
        end
        OpNumSq: begin den_q <= p_q; end
        OpTrial: begin nsq_q <= p_q << 30; end
        OpCompare: begin
          if (p_q <= nsq_q) mag_q <= trial;
          bit_q <= bit_q - 1'b1;
        end
        OpFinish: begin
          r_value_o    <= degen_q ? '0 :
                          (nneg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q}));
          pair_count_o <= cnt_q[15:0];
          degenerate_o <= degen_q;
        end
        OpClear: begin
          cnt_q <= '0; sx_q <= '0; sy_q <= '0; sxx_q <= '0; syy_q <= '0; sxy_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign status_o.mul_done = mdone_q;
  assign status_o.degen    = degen_now;
endmodule

// ----- rtl/mpc_ctrl.sv -----
// Controller: sequences the datapath after the last pair.
// Depends on mpc_pkg.
module mpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  mpc_pkg::dp_status_t  status_i,
  output mpc_pkg::dp_cmd_t     cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import mpc_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StLoad, StMul, StStore, StDenom, StCheck, StSqLoad, StSqMul, StSqStore,
    StTrLoad, StTrMul, StCmp, StFin, StClr
  } state_e;

  state_e     state_q;
  logic [2:0] sel_q;
  logic [3:0] bits_q;

  // Hold state and registered commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; sel_q <= '0; bits_q <= '0;
      cmd_o <= '{op: OpNone, sel: '0, accum: 1'b0};
      busy_o <= 1'b0; done_o <= 1'b0;
    end else begin
      cmd_o  <= '{op: OpNone, sel: sel_q, accum: 1'b0};
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          // Drop busy in the cycle after the result, once the sums are cleared
          busy_o <= go_i;
          if (go_i) begin
            sel_q <= '0; state_q <= StLoad;
          end
        end
        StLoad: begin state_q <= StMul; cmd_o <= '{op: OpLoadA, sel: sel_q, accum: 1'b0}; end
        StMul: begin
          if (status_i.mul_done) state_q <= StStore;
          else cmd_o <= '{op: OpMulStep, sel: sel_q, accum: 1'b0};
        end
        StStore: begin
          case (sel_q[2:1])
            2'd0: cmd_o <= '{op: OpSubX, sel: sel_q, accum: !sel_q[0]};
            2'd1: cmd_o <= '{op: OpSubY, sel: sel_q, accum: !sel_q[0]};
            default: cmd_o <= '{op: OpSubN, sel: sel_q, accum: !sel_q[0]};
          endcase
          if (sel_q == 3'd5) state_q <= StDenom;
          else begin
            sel_q <= sel_q + 1'b1; state_q <= StLoad;
          end
        end
        StDenom: begin cmd_o <= '{op: OpDenom, sel: sel_q, accum: 1'b0}; state_q <= StCheck; end
        StCheck: begin
          if (status_i.degen) state_q <= StFin;
          else begin
            cmd_o <= '{op: OpLoadA, sel: 3'd6, accum: 1'b0}; state_q <= StSqMul; sel_q <= 3'd6;
          end
        end
        StSqMul: begin
          if (status_i.mul_done) begin
            if (sel_q == 3'd6) cmd_o <= '{op: OpNumSq, sel: sel_q, accum: 1'b0};
            else cmd_o <= '{op: OpTrial, sel: sel_q, accum: 1'b0};
            state_q <= StSqLoad;
          end else cmd_o <= '{op: OpMulStep, sel: sel_q, accum: 1'b0};
        end
        StSqLoad: begin
          if (sel_q == 3'd6) begin
            sel_q <= 3'd7; state_q <= StSqMul;
            cmd_o <= '{op: OpLoadA, sel: 3'd7, accum: 1'b0};
          end else begin
            bits_q <= 4'd15; state_q <= StTrMul;
            cmd_o <= '{op: OpLoadB, sel: sel_q, accum: 1'b0};
          end
        end
        StTrMul: begin
          if (status_i.mul_done) begin
            cmd_o <= '{op: OpCompare, sel: sel_q, accum: 1'b0}; state_q <= StCmp;
          end else cmd_o <= '{op: OpMulStep, sel: sel_q, accum: 1'b0};
        end
        StCmp: begin
          bits_q <= bits_q - 1'b1;
          if (bits_q == 4'd1) state_q <= StFin;
          else begin
            cmd_o <= '{op: OpLoadB, sel: sel_q, accum: 1'b0}; state_q <= StTrMul;
          end
        end
        StFin: begin cmd_o <= '{op: OpFinish, sel: sel_q, accum: 1'b0}; state_q <= StClr; end
        StClr: begin
          cmd_o <= '{op: OpClear, sel: sel_q, accum: 1'b0};
          done_o <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- rtl/masked_pearson_correlation.sv -----
// Top level of the masked Pearson correlation block.
// Depends on mpc_pkg, mpc_ctrl and mpc_datapath.
//
// Usage: drive x_sample_i, y_sample_i and last_pair_i with start high; a pair
// transfers at a rising edge with start high and busy low. Pairs with a
// sample equal to missing_code are skipped. Ordinary pairs transfer one per
// cycle, back to back, and raise no busy. A last pair raises busy from the
// next cycle while the shared 32x32 multiplier walks 25 limb products per
// wide product: the six spread and numerator products, the product of the
// two spreads, the squared numerator and fifteen trial squares times the
// denominator. The result transfers with done_o high, sooner when a series
// has zero spread; busy drops in the next cycle while the sums clear, and
// then the next pair can transfer. The result shows for one cycle; the
// receiver cannot stall it. Reset clears all sums and sets missing_code to
// -99. Write missing_code (cfg_we_i, cfg_wdata_i) only while idle.
module masked_pearson_correlation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic signed [15:0] cfg_wdata_i,
  input  logic signed [15:0] x_sample_i,
  input  logic signed [15:0] y_sample_i,
  input  logic               last_pair_i,
  output logic               done_o,
  output logic signed [15:0] r_value_o,
  output logic [15:0]        pair_count_o,
  output logic               degenerate_o
);
  import mpc_pkg::*;

  logic signed [15:0] miss_q;
  dp_cmd_t            cmd;
  dp_status_t         status;
  logic               acc_en, go, ctrl_busy, go_q;

  assign acc_en = start && !busy;
  assign go     = acc_en && last_pair_i;
  assign busy   = ctrl_busy || go_q;

  // Hold the missing code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= -16'sd99; go_q <= 1'b0;
    end else begin
      go_q <= go;
      if (cfg_we_i) miss_q <= cfg_wdata_i;
    end
  end

  mpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .go_i(go_q), .status_i(status), .cmd_o(cmd),
    .busy_o(ctrl_busy), .done_o
  );

  mpc_datapath u_dp (
    .clk_i, .rst_ni, .acc_en_i(acc_en), .x_sample_i, .y_sample_i,
    .missing_code_i(miss_q), .cmd_i(cmd), .status_o(status),
    .r_value_o, .pair_count_o, .degenerate_o
  );

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> busy) else $error("last pair did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !ctrl_busy) else $error("controller busy after result");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> r_value_o == 16'sd0) else $error("degenerate r nonzero");
`endif
endmodule

// ----- tb/sv/masked_pearson_correlation_checker.sv -----
// Checker for the masked Pearson correlation block: watches pair, config and
// result transfers, predicts each result and compares it field by field.
// Depends on nothing but the ports of masked_pearson_correlation.
`timescale 1ns / 1ps
module masked_pearson_correlation_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cfg_we_i,
  input  logic signed [15:0] cfg_wdata_i,
  input  logic signed [15:0] x_sample_i,
  input  logic signed [15:0] y_sample_i,
  input  logic               last_pair_i,
  input  logic               done_i,
  input  logic signed [15:0] r_value_i,
  input  logic [15:0]        pair_count_i,
  input  logic               degenerate_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned MaxPairs = 32768;

  typedef struct {
    logic signed [15:0] r_value;
    logic [15:0]        pair_count;
    logic               degenerate;
  } corr_result_t;

  corr_result_t      corr_q[$];
  logic signed [15:0] missing_code;
  int unsigned       pair_cnt;
  longint            sx, sy, sxx, syy, sxy;

  assign pending_o = corr_q.size();

  // Exact correlation of the current sums, Q1.15 truncated toward zero
  function automatic corr_result_t corr_of_sums();
    corr_result_t res;
    logic signed [255:0] n_w, dx, dy, num, sq, den, trial;
    logic [14:0] mag;
    logic [14:0] c;
    n_w = 256'(signed'(longint'(pair_cnt)));
    dx  = n_w * 256'(sxx) - 256'(sx) * 256'(sx);
    dy  = n_w * 256'(syy) - 256'(sy) * 256'(sy);
    res.pair_count = pair_cnt[15:0];
    res.r_value = '0;
    res.degenerate = 1'b0;
    if (dx <= 0 || dy <= 0) begin
      res.degenerate = 1'b1;
    end else begin
      num = n_w * 256'(sxy) - 256'(sx) * 256'(sy);
      sq  = (num < 0) ? -num : num;
      sq  = (sq * sq) <<< 30;
      den = dx * dy;
      mag = '0;
      for (int b = 14; b >= 0; b--) begin
        c = mag | (15'd1 << b);
        trial = 256'(c) * 256'(c) * den;
        if (trial <= sq) mag = c;
      end
      res.r_value = (num < 0) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    return res;
  endfunction

  // Predict on pair transfers, track config writes, check result strobes
  always @(posedge clk_i or negedge rst_ni) begin
    corr_result_t exp_res;
    longint xv, yv;
    if (!rst_ni) begin
      missing_code = -16'sd99;
      pair_cnt = 0;
      sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
      corr_q.delete();
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (corr_q.size() == 0) begin
          $error("result with nothing expected: r_value %0d", r_value_i);
          fail_count_o++;
        end else begin
          exp_res = corr_q.pop_front();
          if (r_value_i !== exp_res.r_value) begin
            $error("r_value: expected %0d, actual %0d", exp_res.r_value, r_value_i);
            fail_count_o++;
          end
          if (pair_count_i !== exp_res.pair_count) begin
            $error("pair_count: expected %0d, actual %0d", exp_res.pair_count,
                   pair_count_i);
            fail_count_o++;
          end
          if (degenerate_i !== exp_res.degenerate) begin
            $error("degenerate: expected %0d, actual %0d", exp_res.degenerate,
                   degenerate_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        xv = x_sample_i;
        yv = y_sample_i;
        // Skip missing samples; drop pairs past the pair limit
        if (x_sample_i != missing_code && y_sample_i != missing_code &&
            pair_cnt < MaxPairs) begin
          pair_cnt++;
          sx += xv; sy += yv;
          sxx += xv * xv; syy += yv * yv; sxy += xv * yv;
        end
        if (last_pair_i) begin
          corr_q.push_back(corr_of_sums());
          pair_cnt = 0;
          sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        end
      end
      // A new code applies from the next transfer on
      if (cfg_we_i) missing_code = cfg_wdata_i;
    end
  end

endmodule

// ----- tb/sv/masked_pearson_correlation_tb.sv -----
// Testbench top for masked_pearson_correlation: drives directed and random
// pair series in bursts, rewrites missing_code between phases, gives verdict.
// Depends on masked_pearson_correlation and masked_pearson_correlation_checker.
`timescale 1ns / 1ps
module masked_pearson_correlation_tb;

  localparam int IdleLimit = 5000;
  localparam int RandomPairs = 600;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we = 1'b0;
  logic signed [15:0] cfg_wdata = '0;
  logic signed [15:0] x_sample = '0;
  logic signed [15:0] y_sample = '0;
  logic               last_pair = 1'b0;
  logic               done;
  logic signed [15:0] r_value;
  logic [15:0]        pair_count;
  logic               degenerate;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  logic signed [15:0] cur_missing = -16'sd99;

  masked_pearson_correlation i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .x_sample_i   (x_sample),
    .y_sample_i   (y_sample),
    .last_pair_i  (last_pair),
    .done_o       (done),
    .r_value_o    (r_value),
    .pair_count_o (pair_count),
    .degenerate_o (degenerate)
  );

  masked_pearson_correlation_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .x_sample_i   (x_sample),
    .y_sample_i   (y_sample),
    .last_pair_i  (last_pair),
    .done_i       (done),
    .r_value_i    (r_value),
    .pair_count_i (pair_count),
    .degenerate_i (degenerate),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one pair; open a random gap at the end of each burst
  task automatic send_pair(input logic signed [15:0] xv, input logic signed [15:0] yv,
                           input logic lp, input bit gaps = 1'b1);
    int gap;
    if (gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    start <= 1'b1;
    x_sample <= xv;
    y_sample <= yv;
    last_pair <= lp;
    do @(posedge clk_i); while (busy);
  endtask

  // Rewrite missing_code once every expected result has arrived
  task automatic write_missing(input logic signed [15:0] code);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_missing = code;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 11))
      0:       return cur_missing;
      1:       return 16'sh8000;
      2:       return 16'sh7fff;
      3:       return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    int kind;
    logic signed [15:0] xv, yv;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty series, single pair, missing pair as last
    send_pair(16'sd5, 16'sd7, 1'b1);
    send_pair(-16'sd99, 16'sd3, 1'b1);
    send_pair(16'sd1, 16'sd2, 1'b0);
    send_pair(16'sd3, -16'sd99, 1'b1);
    // Perfect positive and near-perfect negative correlation at the field extremes
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b1);
    // Zero spread in one series
    send_pair(16'sd42, 16'sd1, 1'b0);
    send_pair(16'sd42, -16'sd5, 1'b0);
    send_pair(16'sd42, 16'sd9, 1'b1);
    // Partial correlation with a skipped pair inside
    send_pair(16'sd10, 16'sd3, 1'b0);
    send_pair(-16'sd99, -16'sd99, 1'b0);
    send_pair(-16'sd20, 16'sd1, 1'b0);
    send_pair(16'sd7, -16'sd4, 1'b1);

    // Back-to-back series with the most negative value as the missing code
    write_missing(16'sh8000);
    for (int i = 0; i < 40; i++) begin
      send_pair(16'(i * 37), 16'(i * 11 + 5), 1'b0, 1'b0);
    end
    send_pair(16'sd1, 16'sd2, 1'b1);

    // Random series across several missing codes
    sent = 0;
    while (sent < RandomPairs) begin
      if (sent % 150 == 0) begin
        case ((sent / 150) % 4)
          0: write_missing(16'sh7fff);
          1: write_missing(16'sd0);
          2: write_missing(16'($urandom));
          default: write_missing(-16'sd99);
        endcase
      end
      len = $urandom_range(1, 24);
      kind = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        xv = rand_sample();
        case (kind)
          0:       yv = rand_sample();
          1:       yv = (xv >>> 1) + 16'($signed($urandom_range(0, 63)) - 32);
          2:       yv = -(xv >>> 2);
          3:       begin xv = 16'sd300; yv = rand_sample(); end
          default: yv = (xv == 16'sh8000) ? xv : xv;
        endcase
        send_pair(xv, yv, i == len - 1);
        sent++;
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mpc_pkg.sv
rtl/mpc_datapath.sv
rtl/mpc_ctrl.sv
rtl/masked_pearson_correlation.sv
tb/sv/masked_pearson_correlation_checker.sv
tb/sv/masked_pearson_correlation_tb.sv
